// ===== hw/rtl/hc20_pkg.sv =====
// Shared types, constants and helpers for the HChaCha20 subkey derivation block.
// No dependencies; imported by every RTL file of the block.
`timescale 1ns / 1ps

package hc20_pkg;

    localparam int WORD_W    = 32;
    localparam int KEY_REG_W = 64;
    localparam int CFG_IDX_W = 2;

    // Sixteen-word ChaCha matrix, word 0 in the lowest bits.
    typedef logic [15:0][WORD_W-1:0] state_t;

    // "expand 32-byte k" as four little-endian words.
    localparam logic [WORD_W-1:0] EXPAND_0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] EXPAND_1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] EXPAND_2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] EXPAND_3 = 32'h6b20_6574;

    // Quarter-round rotation amounts, in order of use.
    localparam int unsigned ROT_1 = 16;
    localparam int unsigned ROT_2 = 12;
    localparam int unsigned ROT_3 = 8;
    localparam int unsigned ROT_4 = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_2_3 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_4_5 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_6_7 = 2'd3;

    // Per-stage handshake between neighbouring cells.
    typedef struct packed {
        logic valid;
    } stage_ctrl_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

// ===== hw/rtl/hc20_cell.sv =====
// One half-round cell of the HChaCha20 chain: two add/xor/rotate steps on all four
// quarter-round groups, column or diagonal. Depends on hc20_pkg.
`timescale 1ns / 1ps

module hc20_cell #(
    parameter bit DIAGONAL    = 1'b0,
    parameter bit SECOND_HALF = 1'b0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  hc20_pkg::stage_ctrl_t ctrl_in,
    input  hc20_pkg::state_t     state_in,
    output hc20_pkg::stage_ctrl_t ctrl_out,
    output hc20_pkg::state_t     state_out
);
    import hc20_pkg::*;

    // Diagonal groups take b, c, d from rows rotated left by one, two, three.
    localparam logic [1:0] OFF_B = DIAGONAL ? 2'd1 : 2'd0;
    localparam logic [1:0] OFF_C = DIAGONAL ? 2'd2 : 2'd0;
    localparam logic [1:0] OFF_D = DIAGONAL ? 2'd3 : 2'd0;
    localparam int unsigned ROT_D = SECOND_HALF ? ROT_3 : ROT_1;
    localparam int unsigned ROT_B = SECOND_HALF ? ROT_4 : ROT_2;

    logic   valid_reg, valid_next;
    state_t state_reg, state_next;

    always_comb begin
        logic [WORD_W-1:0] a, b, c, d;
        logic [1:0]        gg;
        state_next = state_in;
        for (int g = 0; g < 4; g++) begin
            gg = 2'(g);
            a  = state_in[{2'd0, gg}];
            b  = state_in[{2'd1, gg + OFF_B}];
            c  = state_in[{2'd2, gg + OFF_C}];
            d  = state_in[{2'd3, gg + OFF_D}];
            a  = a + b;
            d  = rotl(d ^ a, ROT_D);
            c  = c + d;
            b  = rotl(b ^ c, ROT_B);
            state_next[{2'd0, gg}]         = a;
            state_next[{2'd1, gg + OFF_B}] = b;
            state_next[{2'd2, gg + OFF_C}] = c;
            state_next[{2'd3, gg + OFF_D}] = d;
        end
    end

    assign valid_next = ctrl_in.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            state_reg <= state_next;
        end
    end

    assign ctrl_out.valid = valid_reg;
    assign state_out      = state_reg;

endmodule

// ===== hw/rtl/hchacha20_subkey_derivation_top.sv =====
// Top level of the HChaCha20 subkey derivation block: key registers, chain of
// half-round cells and output register. Depends on hc20_pkg and hc20_cell.
`timescale 1ns / 1ps

// Usage
//   Write the 256-bit key through cfg_we / cfg_addr / cfg_wdata while the block is
//   idle: index 0 holds key words 0 (low half) and 1 (high half), up to index 3 for
//   words 6 and 7. Each write lands at the rising edge with cfg_we high.
//   Feed nonces on the s_ stream, one 128-bit nonce per transfer. Each nonce gives
//   exactly one 256-bit subkey transfer on the m_ stream, in order.
//   Path: a nonce passes through the chain of cells and then the output register
//   before m_tvalid rises. Every cell of the chain holds one half-round, two of the
//   four dependent add/xor/rotate steps of a quarter round.
//   Throughput: one nonce per cycle while the output is not stalled; the whole chain moves as one pipeline.
//   Stall: while m_tvalid is high and m_tready low, the chain and the output
//   register hold and s_tready drops; the chain keeps taking transfers while the
//   output register is empty or being drained.
//   Reset: aresetn low at a rising edge clears every valid bit and the key
//   registers (an all-zero key).
module hchacha20_subkey_derivation_top #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [hc20_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [hc20_pkg::KEY_REG_W-1:0]  cfg_wdata,
    // nonce stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [127:0]                    s_tdata,   // nonce_word_0 .. nonce_word_3
    // subkey stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [255:0]                    m_tdata    // subkey_word_0 .. subkey_word_7
);
    import hc20_pkg::*;

    localparam int NUM_CELLS = 4 * DOUBLE_ROUNDS;

    logic [KEY_REG_W-1:0] key_reg [4];

    // Key registers: write only while idle, so the chain entry may read them freely.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_KEY_0_1: key_reg[0] <= cfg_wdata;
                CFG_KEY_2_3: key_reg[1] <= cfg_wdata;
                CFG_KEY_4_5: key_reg[2] <= cfg_wdata;
                CFG_KEY_6_7: key_reg[3] <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Advance the whole chain whenever the output register can take a new item.
    logic advance;
    logic m_valid_reg, m_valid_next;
    logic [255:0] m_data_reg, m_data_next;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    // Build the starting matrix: constants, key words, nonce words.
    state_t init_state;
    always_comb begin
        init_state[0] = EXPAND_0;
        init_state[1] = EXPAND_1;
        init_state[2] = EXPAND_2;
        init_state[3] = EXPAND_3;
        for (int i = 0; i < 4; i++) begin
            init_state[4 + 2 * i] = key_reg[i][WORD_W-1:0];
            init_state[5 + 2 * i] = key_reg[i][KEY_REG_W-1:WORD_W];
            init_state[12 + i]    = s_tdata[i * WORD_W +: WORD_W];
        end
    end

    stage_ctrl_t chain_ctrl  [NUM_CELLS + 1];
    state_t      chain_state [NUM_CELLS + 1];

    assign chain_ctrl[0].valid = s_tvalid;
    assign chain_state[0]      = init_state;

    // Cell k: bit 0 picks the half of the quarter round, bit 1 column or diagonal.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        hc20_cell #(
            .DIAGONAL    (((k / 2) % 2) == 1),
            .SECOND_HALF ((k % 2) == 1)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .ctrl_in   (chain_ctrl[k]),
            .state_in  (chain_state[k]),
            .ctrl_out  (chain_ctrl[k + 1]),
            .state_out (chain_state[k + 1])
        );
    end

    // Output register: drop nothing, hold while the receiver stalls.
    assign m_valid_next = chain_ctrl[NUM_CELLS].valid;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m_data_next[i * WORD_W +: WORD_W]       = chain_state[NUM_CELLS][i];
            m_data_next[(i + 4) * WORD_W +: WORD_W] = chain_state[NUM_CELLS][12 + i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/hc20_checker.sv =====
// Port-level checker for the HChaCha20 subkey derivation top level, with its bind.
// Depends on hc20_pkg and hchacha20_subkey_derivation_top.
`timescale 1ns / 1ps

module hc20_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata
);
    import hc20_pkg::*;

    // A stalled result holds its value.
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Input side is ready exactly when the output side can move.
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output drain");

    // An offered nonce is taken whenever the output register is empty.
    a_take_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !m_tvalid |-> s_tready)
        else $error("nonce refused with the output register empty");

endmodule

bind hchacha20_subkey_derivation_top hc20_checker u_hc20_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
